[design/ffba_pkg.sv]
// ffba_pkg: shared types and codes for the first-fit block allocator
// holds beat payload structs, action and status codes, controller/datapath structs
// no dependencies
package ffba_pkg;

  localparam int REQ_W = 11;
  localparam int OFF_W = 10;

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset_in;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] payload_offset_out;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       take_item;
    logic       init_write;
    logic       mod_step;
    logic       scan_step;
    logic       free_write;
    logic       hit_write;
    logic       shift_step;
    logic       split_write;
    logic       res_set;
    logic [1:0] res_code;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       mod_done;
    logic       scan_hit;
    logic       scan_miss;
    logic       split_ok;
    logic       shift_done;
    logic       out_free;
  } dp_sts_t;

endpackage

[design/ffba_ctrl.sv]
// ffba_ctrl: sequencing state machine of the first-fit block allocator
// depends on ffba_pkg for command and status structs and action codes
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_action_i,
  output logic                in_stall_o,
  output ffba_pkg::dp_cmd_t   cmd_o,
  input  ffba_pkg::dp_sts_t   sts_i
);

  localparam logic [3:0] S_BOOT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_AHIT  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_SPLIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_BOOT: begin
        cmd_o.init_write = 1'b1;
        state_d          = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          unique case (in_action_i)
            ffba_pkg::ACT_ALLOC: state_d = S_MOD;
            ffba_pkg::ACT_FREE:  state_d = S_SCAN;
            ffba_pkg::ACT_RESET: state_d = S_INIT;
            default: begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ffba_pkg::ST_OK;
              state_d        = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd_o.init_write = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_code   = ffba_pkg::ST_OK;
        state_d          = S_DONE;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          if (sts_i.action == ffba_pkg::ACT_FREE) begin
            cmd_o.free_write = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_code   = ffba_pkg::ST_OK;
            state_d          = S_DONE;
          end else begin
            state_d = S_AHIT;
          end
        end else if (sts_i.scan_miss) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = (sts_i.action == ffba_pkg::ACT_FREE) ?
                           ffba_pkg::ST_BADFREE : ffba_pkg::ST_NOFIT;
          state_d        = S_DONE;
        end
      end
      S_AHIT: begin
        cmd_o.hit_write = 1'b1;
        state_d         = sts_i.split_ok ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd_o.split_write = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_BOOT;
      end
    endcase
  end

endmodule

[design/ffba_dp.sv]
// ffba_dp: datapath of the first-fit block allocator
// block table memory, alignment remainder unit, scan and shift pointers, result register
// depends on ffba_pkg for payload, command and status types
module ffba_dp #(
  parameter int ARENA_BYTES  = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 16,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffba_pkg::in_t       in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output ffba_pkg::out_t      out_data_o,
  input  ffba_pkg::dp_cmd_t   cmd_i,
  output ffba_pkg::dp_sts_t   sts_o
);

  localparam int REQ_W = ffba_pkg::REQ_W;
  localparam int OFF_W = ffba_pkg::OFF_W;
  localparam int SW    = $clog2(ARENA_BYTES + 1);
  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int W     = ((SW > REQ_W) ? SW : REQ_W) + 2;
  localparam int RW    = $clog2(ALIGN_BYTES) + 1;
  localparam int SH    = REQ_W + $clog2(ALIGN_BYTES);
  localparam int PW    = SH + REQ_W;
  localparam int MW    = REQ_W + 2;

  localparam logic [W-1:0]  HDR_W  = W'(HEADER_BYTES);
  localparam logic [W-1:0]  ALN_W  = W'(ALIGN_BYTES);
  localparam logic [SW-1:0] SIZE0  = SW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [IW-1:0] ONE_I  = IW'(1);
  // scaled reciprocal of the alignment unit, exact for every request value
  localparam logic [MW-1:0] RECIP  = MW'((2**SH + ALIGN_BYTES - 1) / ALIGN_BYTES);

  // block table
  logic [SW-1:0] start_mem [MAX_BLOCKS];
  logic [SW-1:0] size_mem  [MAX_BLOCKS];
  logic          used_mem  [MAX_BLOCKS];

  // item registers
  logic [1:0]       act_q;
  logic [REQ_W-1:0] req_q;
  logic [OFF_W-1:0] pin_q;

  // alignment remainder by reciprocal multiply
  logic [RW-1:0]    rem_q, rem_d;
  logic [PW-1:0]    quo_prod;
  logic [REQ_W-1:0] quo;
  logic [W-1:0]     quo_ext, quo_mul, rem_full;

  logic [CW-1:0] count_q;
  logic [CW-1:0] nxt_q;
  logic          rdv_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] sp_q, shp_q;
  logic          shv_q;

  logic [SW-1:0] rd_start_q, rd_size_q;
  logic          rd_used_q;
  logic [SW-1:0] hit_start_q, hit_size_q;

  logic [1:0]       res_status_q;
  logic [OFF_W-1:0] res_off_q;
  logic             out_valid_q;
  ffba_pkg::out_t   out_data_q;

  // arithmetic
  logic [W-1:0] req_ext, pin_ext, rem_ext, pad, step;
  logic [W-1:0] rd_start_ext, rd_size_ext, hit_start_ext, hit_size_ext;
  logic [W-1:0] rd_payload, split_start, split_size;
  logic [CW-1:0] cnt_m1;
  logic         hit, issue, shift_rd;

  // memory ports
  logic          rd_en;
  logic [IW-1:0] ra;
  logic          we_start, we_size, we_used;
  logic [IW-1:0] wa;
  logic [SW-1:0] wd_start, wd_size;
  logic          wd_used;

  assign req_ext       = {{(W-REQ_W){1'b0}}, req_q};
  assign pin_ext       = {{(W-OFF_W){1'b0}}, pin_q};
  assign rem_ext       = {{(W-RW){1'b0}}, rem_q};
  assign rd_start_ext  = {{(W-SW){1'b0}}, rd_start_q};
  assign rd_size_ext   = {{(W-SW){1'b0}}, rd_size_q};
  assign hit_start_ext = {{(W-SW){1'b0}}, hit_start_q};
  assign hit_size_ext  = {{(W-SW){1'b0}}, hit_size_q};

  // round up to the alignment unit
  assign pad         = (rem_q == '0) ? req_ext : (req_ext + ALN_W - rem_ext);
  assign step        = pad + HDR_W;
  assign rd_payload  = rd_start_ext + HDR_W;
  assign split_start = hit_start_ext + step;
  assign split_size  = hit_size_ext - step;
  assign cnt_m1      = count_q - ONE_C;

  // quotient from the reciprocal, remainder from the quotient
  assign quo_prod = {{(PW-REQ_W){1'b0}}, req_q} * {{(PW-MW){1'b0}}, RECIP};
  assign quo      = quo_prod[SH +: REQ_W];
  assign quo_ext  = {{(W-REQ_W){1'b0}}, quo};
  assign quo_mul  = quo_ext * ALN_W;
  assign rem_full = req_ext - quo_mul;
  assign rem_d    = rem_full[RW-1:0];

  always_comb begin
    hit = 1'b0;
    if (rdv_q) begin
      if (act_q == ffba_pkg::ACT_FREE) begin
        hit = (rd_payload == pin_ext);
      end else begin
        hit = !rd_used_q && (rd_size_ext >= req_ext);
      end
    end
  end

  assign issue    = cmd_i.scan_step && !hit && (nxt_q < count_q);
  assign shift_rd = cmd_i.shift_step && (sp_q > idx_q);

  assign sts_o.action     = act_q;
  assign sts_o.mod_done   = 1'b1;
  assign sts_o.scan_hit   = hit;
  assign sts_o.scan_miss  = !hit && (nxt_q >= count_q);
  assign sts_o.split_ok   = (rd_size_ext >= step + ALN_W) && (count_q < MAXC);
  assign sts_o.shift_done = (sp_q <= idx_q) && !shv_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // read port select
  always_comb begin
    rd_en = issue || shift_rd;
    ra    = shift_rd ? sp_q : nxt_q[IW-1:0];
  end

  // write port select
  always_comb begin
    we_start = 1'b0;
    we_size  = 1'b0;
    we_used  = 1'b0;
    wa       = idx_q;
    wd_start = rd_start_q;
    wd_size  = rd_size_q;
    wd_used  = rd_used_q;
    priority if (cmd_i.init_write) begin
      we_start = 1'b1;
      we_size  = 1'b1;
      we_used  = 1'b1;
      wa       = '0;
      wd_start = '0;
      wd_size  = SIZE0;
      wd_used  = 1'b0;
    end else if (cmd_i.free_write) begin
      we_used = 1'b1;
      wd_used = 1'b0;
    end else if (cmd_i.hit_write) begin
      we_used = 1'b1;
      wd_used = 1'b1;
      we_size = sts_o.split_ok;
      wd_size = pad[SW-1:0];
    end else if (cmd_i.shift_step && shv_q) begin
      we_start = 1'b1;
      we_size  = 1'b1;
      we_used  = 1'b1;
      wa       = shp_q + ONE_I;
    end else if (cmd_i.split_write) begin
      we_start = 1'b1;
      we_size  = 1'b1;
      we_used  = 1'b1;
      wa       = idx_q + ONE_I;
      wd_start = split_start[SW-1:0];
      wd_size  = split_size[SW-1:0];
      wd_used  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_start) begin
      start_mem[wa] <= wd_start;
    end
    if (we_size) begin
      size_mem[wa] <= wd_size;
    end
    if (we_used) begin
      used_mem[wa] <= wd_used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= start_mem[ra];
      rd_size_q  <= size_mem[ra];
      rd_used_q  <= used_mem[ra];
    end
  end

  // item, pointer, hit, result and output data registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      act_q <= in_data_i.action;
      req_q <= in_data_i.request_bytes;
      pin_q <= in_data_i.payload_offset_in;
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
    end
    if (issue) begin
      idx_q <= nxt_q[IW-1:0];
    end
    if (cmd_i.hit_write) begin
      hit_start_q <= rd_start_q;
      hit_size_q  <= rd_size_q;
    end
    if (shift_rd) begin
      shp_q <= sp_q;
    end
    if (cmd_i.hit_write) begin
      res_status_q <= ffba_pkg::ST_OK;
      res_off_q    <= rd_payload[OFF_W-1:0];
    end else if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_off_q    <= '0;
    end
    if (cmd_i.out_load) begin
      out_data_q.status             <= res_status_q;
      out_data_q.payload_offset_out <= res_off_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= ONE_C;
      nxt_q       <= '0;
      rdv_q       <= 1'b0;
      sp_q        <= '0;
      shv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_write) begin
        count_q <= ONE_C;
      end else if (cmd_i.split_write) begin
        count_q <= count_q + ONE_C;
      end

      if (cmd_i.take_item) begin
        nxt_q <= '0;
        rdv_q <= 1'b0;
      end else if (issue) begin
        nxt_q <= nxt_q + ONE_C;
        rdv_q <= 1'b1;
      end

      if (cmd_i.hit_write) begin
        sp_q  <= cnt_m1[IW-1:0];
        shv_q <= 1'b0;
      end else if (cmd_i.shift_step) begin
        shv_q <= shift_rd;
        if (shift_rd) begin
          sp_q <= sp_q - ONE_I;
        end
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/first_fit_block_allocator.sv]
// first-fit block allocator, one beat in and one result beat out per item
// allocate: a remainder step, then a scan and a shift of later entries that together
//   walk the N blocks once, then, when the rest is large enough, a split write of the free rest
// free: a scan for the block whose payload offset matches; arena reset rewrites the single free block
// the scan and shift rate is set by the single read port of the block table memory
// after rst_ni, a boot state writes the single free block before the first beat is taken
module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 16,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ffba_pkg::in_t    in_data_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ffba_pkg::out_t   out_data_o
);

  // command and status between sequencer and datapath
  ffba_pkg::dp_cmd_t cmd;
  ffba_pkg::dp_sts_t sts;

  // the sequencer decides the action straight from the incoming beat so that
  // the state it enters on accept already runs the remainder, the scan or the arena reset
  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // the datapath holds the address-ordered block table, the request
  // alignment unit and the output register; a finished result may wait
  // there while the next beat is already being worked on
  ffba_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
